// File: hdl/bdq_pkg.sv
// Shared types and codes for the bounded deque with search.
package bdq_pkg;

	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [OPCODE_W-1:0]       opcode;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [COUNT_W-1:0]  count;
	} rsp_t;

endpackage

// File: hdl/bounded_deque_with_search.sv
// Bounded double-ended queue of DEPTH signed 32-bit words with membership search.
// Each accepted word yields one response (status, found flag, count after the
// operation; count is the low five bits of the fill level). Pushes, pops and
// unknown opcodes yield their result in their accept cycle. A search walks the
// stored words from the front through the single read port of the ring store
// and one comparator, one word per cycle; it answers at once when the store is
// empty, and it stops early on a hit.
// No new request is accepted while a search runs, nor while an undelivered
// response would be overwritten.
module bounded_deque_with_search #(
	parameter int unsigned DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bdq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bdq_pkg::rsp_t  rsp
);
	import bdq_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);

	logic               seq_idle;
	logic               res_valid;
	rsp_t               res;
	logic               req_fire;
	logic               slot_free;
	logic               mem_we, mem_re;
	logic [IW-1:0]      mem_waddr, mem_raddr;
	logic [VALUE_W-1:0] mem_wdata, mem_rdata;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = seq_idle && slot_free;
	assign req_fire  = req_valid && req_ready;

	bdq_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_fire  (req_fire),
		.req       (req),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bdq_store #(
		.DEPTH(DEPTH),
		.IW   (IW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_res_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> slot_free)
		else $error("response produced while output word still pending");

	a_short_ops_answer_now: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.opcode != OP_SEARCH) |-> res_valid)
		else $error("non-search request did not respond in its accept cycle");

	a_search_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && !res_valid |=> !seq_idle && !req_ready)
		else $error("pending search did not hold off new requests");

endmodule

// File: hdl/bdq_store.sv
// Ring store: one write port, one read port with registered read data.
module bdq_store #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned IW    = 4
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [IW-1:0]                 waddr,
	input  logic [bdq_pkg::VALUE_W-1:0]   wdata,
	input  logic                          re,
	input  logic [IW-1:0]                 raddr,
	output logic [bdq_pkg::VALUE_W-1:0]   rdata
);
	import bdq_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/bdq_seq.sv
// Sequencer: ring pointers, fill count, and the search loop over one shared comparator.
module bdq_seq #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_fire,
	input  bdq_pkg::req_t                      req,
	output logic                               idle,
	output logic                               res_valid,
	output bdq_pkg::rsp_t                      res,
	output logic                               mem_we,
	output logic [$clog2(DEPTH)-1:0]           mem_waddr,
	output logic [bdq_pkg::VALUE_W-1:0]        mem_wdata,
	output logic                               mem_re,
	output logic [$clog2(DEPTH)-1:0]           mem_raddr,
	input  logic [bdq_pkg::VALUE_W-1:0]        mem_rdata
);
	import bdq_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SRCH = 2'b10
	} state_t;

	state_t             state_q, state_n;
	logic [IW-1:0]      head_q, head_n;
	logic [IW-1:0]      tail_q, tail_n;
	logic [CW-1:0]      cnt_q, cnt_n;
	logic [VALUE_W-1:0] key_q, key_n;
	logic [IW-1:0]      rd_ptr_q, rd_ptr_n;
	logic [CW-1:0]      iss_q, iss_n;
	logic               rd_vld_q, rd_vld_n;
	logic               rd_last_q, rd_last_n;

	logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec, rd_ptr_inc;
	logic          is_full, is_empty, hit;

	assign head_inc   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dec   = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_inc   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dec   = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
	assign is_full    = (cnt_q == FULL_CNT);
	assign is_empty   = (cnt_q == '0);
	assign hit        = rd_vld_q && (mem_rdata == key_q);

	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_n    = state_q;
		head_n     = head_q;
		tail_n     = tail_q;
		cnt_n      = cnt_q;
		key_n      = key_q;
		rd_ptr_n   = rd_ptr_q;
		iss_n      = iss_q;
		rd_vld_n   = 1'b0;
		rd_last_n  = 1'b0;
		res_valid  = 1'b0;
		res.status = STAT_OK;
		res.found  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = tail_q;
		mem_wdata  = req.value;
		mem_re     = 1'b0;
		mem_raddr  = rd_ptr_q;

		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					res_valid = 1'b1;
					case (req.opcode)
						OP_PUSH_FRONT: begin
							if (is_full) begin
								res.status = STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = head_dec;
								head_n    = head_dec;
								cnt_n     = cnt_q + 1'b1;
							end
						end
						OP_PUSH_BACK: begin
							if (is_full) begin
								res.status = STAT_FULL;
							end else begin
								mem_we = 1'b1;
								tail_n = tail_inc;
								cnt_n  = cnt_q + 1'b1;
							end
						end
						OP_POP_FRONT: begin
							if (is_empty) begin
								res.status = STAT_EMPTY;
							end else begin
								head_n = head_inc;
								cnt_n  = cnt_q - 1'b1;
							end
						end
						OP_POP_BACK: begin
							if (is_empty) begin
								res.status = STAT_EMPTY;
							end else begin
								tail_n = tail_dec;
								cnt_n  = cnt_q - 1'b1;
							end
						end
						OP_SEARCH: begin
							// empty store answers at once; otherwise walk from the head
							if (!is_empty) begin
								res_valid = 1'b0;
								state_n   = S_SRCH;
								key_n     = req.value;
								rd_ptr_n  = head_q;
								iss_n     = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SRCH: begin
				if (rd_vld_q && (hit || rd_last_q)) begin
					res_valid = 1'b1;
					res.found = hit;
					state_n   = S_IDLE;
				end else if (iss_q != cnt_q) begin
					// issue the next read while comparing the previous word
					mem_re    = 1'b1;
					rd_ptr_n  = rd_ptr_inc;
					iss_n     = iss_q + 1'b1;
					rd_vld_n  = 1'b1;
					rd_last_n = (iss_q == CW'(cnt_q - 1'b1));
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase

		res.count = COUNT_W'(cnt_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
			iss_q     <= '0;
			rd_ptr_q  <= '0;
		end else begin
			state_q   <= state_n;
			head_q    <= head_n;
			tail_q    <= tail_n;
			cnt_q     <= cnt_n;
			rd_vld_q  <= rd_vld_n;
			rd_last_q <= rd_last_n;
			iss_q     <= iss_n;
			rd_ptr_q  <= rd_ptr_n;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_n;
	end

endmodule

// File: dv/tb_bounded_deque_with_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded deque with search: random and directed deque traffic.
module tb_bounded_deque_with_search;
	import bdq_pkg::*;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned N_WORDS    = 1550;
	localparam int unsigned QUIET_MAX  = 2000;
	localparam int unsigned DRAIN_CYC  = 2 * DEPTH + 8;
	localparam int unsigned HOLD_CYC   = 300;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	// Shadow copy of the deque; predicts one response per accepted request.
	class deque_tracker;
		logic [VALUE_W-1:0] ring [DEPTH];
		int unsigned head;
		int unsigned fill;
		rsp_t pending [$];
		int unsigned errors;

		function new();
			head = 0;
			fill = 0;
			errors = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int unsigned i;
			e = '0;
			e.status = STAT_OK;
			case (r.opcode)
				OP_PUSH_FRONT: begin
					if (fill >= DEPTH) begin
						e.status = STAT_FULL;
					end else begin
						head = (head == 0) ? DEPTH - 1 : head - 1;
						ring[head] = r.value;
						fill++;
					end
				end
				OP_PUSH_BACK: begin
					if (fill >= DEPTH) begin
						e.status = STAT_FULL;
					end else begin
						ring[(head + fill) % DEPTH] = r.value;
						fill++;
					end
				end
				OP_POP_FRONT: begin
					if (fill == 0) begin
						e.status = STAT_EMPTY;
					end else begin
						head = (head + 1) % DEPTH;
						fill--;
					end
				end
				OP_POP_BACK: begin
					if (fill == 0) e.status = STAT_EMPTY;
					else fill--;
				end
				OP_SEARCH: begin
					for (i = 0; i < fill; i++)
						if (ring[(head + i) % DEPTH] == r.value) e.found = 1'b1;
				end
				default: begin
				end
			endcase
			e.count = COUNT_W'(fill);
			pending.push_back(e);
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("response with no request waiting: status %0d found %0d count %0d",
					a.status, a.found, a.count);
				errors++;
			end else begin
				e = pending.pop_front();
				if (a.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, a.status);
					errors++;
				end
				if (a.found !== e.found) begin
					$error("found: expected %0d, actual %0d", e.found, a.found);
					errors++;
				end
				if (a.count !== e.count) begin
					$error("count: expected %0d, actual %0d", e.count, a.count);
					errors++;
				end
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	deque_tracker tracker = new();
	int unsigned words_sent = 0;
	bit gaps_on = 1'b1;
	int unsigned quiet = 0;

	bounded_deque_with_search #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Check before noting: a response in the same cycle always belongs to an older word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) tracker.check_response(rsp);
			if (req_valid && req_ready) tracker.note_request(req);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Offer one word and hold it until accepted; random gaps go in front.
	task automatic send_word(input req_t w);
		if (gaps_on) begin
			while ($urandom_range(99) < 6) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		words_sent++;
	endtask

	task automatic wait_drained();
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	initial begin : receiver
		bit held_once;
		int unsigned n;
		held_once = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (!held_once && words_sent >= 400) begin
				// Hold off long enough for the block to back up and stall its input.
				held_once = 1'b1;
				rsp_ready <= 1'b0;
				for (n = 0; n < HOLD_CYC; n++) @(posedge clk);
			end else begin
				if (words_sent >= 1000 && words_sent < 1300) rsp_ready <= 1'b1;
				else rsp_ready <= ($urandom_range(99) >= 6);
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		req_t w;
		logic signed [VALUE_W-1:0] recent [$];
		int unsigned real_cnt;
		int unsigned mode;
		int unsigned roll;
		int unsigned push_pct;
		int unsigned pop_pct;
		bit paused;
		real_cnt = 0;
		mode = 2;
		paused = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, extreme values, hits and misses, unused opcodes.
		send_word(req_t'{OP_POP_FRONT, 32'sd0});
		send_word(req_t'{OP_POP_BACK, 32'sd0});
		send_word(req_t'{OP_SEARCH, 32'sd0});
		send_word(req_t'{OP_PUSH_FRONT, VAL_MIN});
		send_word(req_t'{OP_PUSH_BACK, VAL_MAX});
		send_word(req_t'{OP_PUSH_FRONT, -32'sd1});
		send_word(req_t'{OP_PUSH_BACK, 32'sd0});
		send_word(req_t'{OP_SEARCH, VAL_MIN});
		send_word(req_t'{OP_SEARCH, VAL_MAX});
		send_word(req_t'{OP_SEARCH, 32'sd0});
		send_word(req_t'{OP_SEARCH, 32'sh5555_5555});
		send_word(req_t'{3'd5, VAL_MAX});
		send_word(req_t'{3'd6, -32'sd1});
		send_word(req_t'{3'd7, 32'sd0});
		send_word(req_t'{OP_POP_FRONT, 32'sd0});
		send_word(req_t'{OP_POP_BACK, -32'sd1});
		send_word(req_t'{OP_SEARCH, VAL_MIN});

		while (real_cnt < N_WORDS) begin
			if ($urandom_range(39) == 0) mode = $urandom_range(3);
			case (mode)
				0: begin push_pct = 70; pop_pct = 15; end
				1: begin push_pct = 20; pop_pct = 65; end
				2: begin push_pct = 40; pop_pct = 35; end
				default: begin push_pct = 25; pop_pct = 20; end
			endcase
			gaps_on = !(real_cnt >= 1000 && real_cnt < 1300);

			if (!paused && real_cnt >= 800) begin
				// Pause the sender until every response is back.
				paused = 1'b1;
				req_valid <= 1'b0;
				wait_drained();
			end

			w.value = $urandom();
			roll = $urandom_range(9);
			if (roll == 0) begin
				case ($urandom_range(3))
					0: w.value = VAL_MIN;
					1: w.value = VAL_MAX;
					2: w.value = 32'sd0;
					default: w.value = -32'sd1;
				endcase
			end

			roll = $urandom_range(99);
			if (roll < 3) begin
				w.opcode = OPCODE_W'($urandom_range(7, 5));
			end else begin
				roll = $urandom_range(99);
				if (roll < push_pct) begin
					w.opcode = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
					recent.push_back(w.value);
					if (recent.size() > 24) void'(recent.pop_front());
				end else if (roll < push_pct + pop_pct) begin
					w.opcode = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
				end else begin
					w.opcode = OP_SEARCH;
					// Mostly look for something pushed lately, so hits are common.
					if (recent.size() != 0 && $urandom_range(99) < 60)
						w.value = recent[$urandom_range(recent.size() - 1)];
				end
				real_cnt++;
			end
			send_word(w);
		end

		req_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (tracker.pending.size() != 0)
			$error("%0d responses never arrived", tracker.pending.size());
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/bdq_pkg.sv
hdl/bdq_store.sv
hdl/bdq_seq.sv
hdl/bounded_deque_with_search.sv
dv/tb_bounded_deque_with_search.sv
